### sv/tlcdf_pkg.sv
// Package for the two-level CDF symbol lookup.
// Holds field widths and operation codes shared by the top level, the counter and the checker.
// No dependencies.
package tlcdf_pkg;

    // Field widths of the request and the result
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int SYMBOL_W = 8;

    // Width of the group and lane fields inside an index or a symbol
    localparam int FIELD_W  = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE_COARSE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_FINE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP       = 2'd2;

endpackage

### sv/two_level_cdf_symbol_lookup.sv
// Top level of the two-level CDF symbol lookup for an rANS decoder.
// Depends on tlcdf_pkg and tlcdf_count_le.
//
// Usage:
//   One request channel (req_valid/req_ready with operation, index, value) and one
//   result channel (res_valid/res_ready with symbol). A request either writes a coarse
//   group start (index 0..GROUPS-1), writes a fine offset (index = group*16 + lane),
//   or looks up the symbol for a cumulative value. Only lookups return a result.
//   A lookup accepted into the request register passes the coarse search and fine row
//   read registers, then the result register drives its symbol on the result port.
//   Throughput: one request per cycle unless the receiver stalls, set by a four-register
//   pipeline (request register, coarse search, fine row read, result register). A write
//   lands as it leaves the request register, held there by a stalled lookup ahead; every
//   lookup accepted after it sees it. When the receiver stalls, the result register
//   holds and earlier stages keep filling until each holds a request; only then does
//   req_ready drop. Reset empties the pipeline. The tables are not cleared: every entry
//   a lookup compares must be written first.
module two_level_cdf_symbol_lookup
    import tlcdf_pkg::*;
#(
    parameter int GROUPS = 16,
    parameter int LANES  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [INDEX_W-1:0]  index,
    input  logic [VALUE_W-1:0]  value,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [SYMBOL_W-1:0] symbol
);

    localparam int GW = $clog2(GROUPS);
    localparam int LW = $clog2(LANES);
    localparam logic [INDEX_W-1:0] COARSE_LIM = INDEX_W'(GROUPS);
    localparam logic [FIELD_W:0]   GROUP_LIM  = (FIELD_W + 1)'(GROUPS);
    localparam logic [FIELD_W:0]   LANE_LIM   = (FIELD_W + 1)'(LANES);

    // Request register
    logic               s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]    s1_op_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    // Coarse search result
    logic               s2_valid_reg, s2_valid_next;
    logic [GW-1:0]      s2_group_reg, s2_group_next;
    logic [VALUE_W-1:0] s2_value_reg;

    // Remainder and fine row
    logic                            s3_valid_reg, s3_valid_next;
    logic [GW-1:0]                   s3_group_reg;
    logic [VALUE_W-1:0]              s3_rem_reg, s3_rem_next;
    logic [LANES-1:0][VALUE_W-1:0]   s3_row_reg;
    logic [LW-1:0]                   lane_pos;

    // Result register
    logic                res_valid_reg, res_valid_next;
    logic [SYMBOL_W-1:0] symbol_reg, symbol_next;

    // Tables
    logic [GROUPS-1:0][VALUE_W-1:0] coarse_reg;
    logic [LANES-1:0][VALUE_W-1:0]  fine_mem [GROUPS];

    logic out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_is_lookup, req_fire;
    logic coarse_wr, fine_wr;
    logic [GW-1:0] wr_group;
    logic [LW-1:0] wr_lane;

    // Stage advance chain, from the result end back to the request register;
    // writes also wait for the coarse stage so they never overtake a held lookup
    always_comb
    begin
        out_free     = !res_valid_reg || res_ready;
        s3_adv       = s3_valid_reg && out_free;
        s3_free      = !s3_valid_reg || s3_adv;
        s2_adv       = s2_valid_reg && s3_free;
        s2_free      = !s2_valid_reg || s2_adv;
        s1_is_lookup = (s1_op_reg == OP_LOOKUP);
        s1_adv       = s1_valid_reg && s2_free;
        req_ready    = !s1_valid_reg || s1_adv;
        req_fire     = req_valid && req_ready;
    end

    // Occupancy of each stage
    always_comb
    begin
        s1_valid_next  = req_fire || (s1_valid_reg && !s1_adv);
        s2_valid_next  = (s1_adv && s1_is_lookup) || (s2_valid_reg && !s2_adv);
        s3_valid_next  = s2_adv || (s3_valid_reg && !s3_adv);
        res_valid_next = s3_adv || (res_valid_reg && !res_ready);
    end

    // Table writes leave from the request register
    always_comb
    begin
        wr_group  = s1_index_reg[FIELD_W +: GW];
        wr_lane   = s1_index_reg[LW-1:0];
        coarse_wr = s1_adv && (s1_op_reg == OP_WRITE_COARSE) && (s1_index_reg < COARSE_LIM);
        fine_wr   = s1_adv && (s1_op_reg == OP_WRITE_FINE)
                    && ({1'b0, s1_index_reg[INDEX_W-1:FIELD_W]} < GROUP_LIM)
                    && ({1'b0, s1_index_reg[FIELD_W-1:0]} < LANE_LIM);
    end

    // Coarse search: group whose start is the last one not above the value
    tlcdf_count_le #(
        .N (GROUPS)
    ) u_coarse_count (
        .entries (coarse_reg),
        .key     (s1_value_reg),
        .pos     (s2_group_next)
    );

    // Remainder within the group, wrapping
    assign s3_rem_next = s2_value_reg - coarse_reg[s2_group_reg];

    // Fine search within the group's row
    tlcdf_count_le #(
        .N (LANES)
    ) u_fine_count (
        .entries (s3_row_reg),
        .key     (s3_rem_reg),
        .pos     (lane_pos)
    );

    assign symbol_next = {FIELD_W'(s3_group_reg), FIELD_W'(lane_pos)};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg    <= operation;
            s1_index_reg <= index;
            s1_value_reg <= value;
        end
        if (s1_adv && s1_is_lookup)
        begin
            s2_group_reg <= s2_group_next;
            s2_value_reg <= s1_value_reg;
        end
        if (s2_adv)
        begin
            s3_group_reg <= s2_group_reg;
            s3_rem_reg   <= s3_rem_next;
        end
        if (s3_adv)
        begin
            symbol_reg <= symbol_next;
        end
        if (coarse_wr)
        begin
            coarse_reg[s1_index_reg[GW-1:0]] <= s1_value_reg;
        end
    end

    // Fine table: lane write, registered row read
    always_ff @(posedge clk)
    begin
        if (fine_wr)
        begin
            fine_mem[wr_group][wr_lane] <= s1_value_reg;
        end
        if (s2_adv)
        begin
            s3_row_reg <= fine_mem[s2_group_reg];
        end
    end

    assign res_valid = res_valid_reg;
    assign symbol    = symbol_reg;

endmodule

### sv/tlcdf_count_le.sv
// Counts table entries less than or equal to a key and returns that count minus one,
// clamped to zero when nothing matches. Depends on tlcdf_pkg.
module tlcdf_count_le
    import tlcdf_pkg::*;
#(
    parameter int N = 16
)
(
    input  logic [N-1:0][VALUE_W-1:0] entries,
    input  logic [VALUE_W-1:0]        key,
    output logic [$clog2(N)-1:0]      pos
);

    localparam int CW = $clog2(N + 1);
    localparam int PW = $clog2(N);

    logic [N-1:0]  hit;
    logic [CW-1:0] cnt;

    // Compare every entry, add up the hits, step back by one
    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < N; i++)
        begin
            hit[i] = (entries[i] <= key);
        end
        for (int i = 0; i < N; i++)
        begin
            cnt = cnt + CW'(hit[i]);
        end
        if (cnt == '0)
        begin
            pos = '0;
        end
        else
        begin
            pos = PW'(cnt - CW'(1));
        end
    end

endmodule

### sv/tlcdf_checker.sv
// Port-level checker for the two-level CDF symbol lookup, bound to the top level.
// Depends on tlcdf_pkg and two_level_cdf_symbol_lookup.
module tlcdf_checker
    import tlcdf_pkg::*;
#(
    parameter int GROUPS = 16,
    parameter int LANES  = 16
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic [SYMBOL_W-1:0] symbol
);

    localparam logic [FIELD_W:0] GROUP_LIM = (FIELD_W + 1)'(GROUPS);
    localparam logic [FIELD_W:0] LANE_LIM  = (FIELD_W + 1)'(LANES);

    // Reset empties the result register by the following edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(symbol)))
        else $error("stalled result changed or dropped");

    // With no result waiting nothing can back up, so requests are taken
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request refused with an empty result register");

    // Group and lane stay inside the configured table size
    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (({1'b0, symbol[SYMBOL_W-1:FIELD_W]} < GROUP_LIM)
                    && ({1'b0, symbol[FIELD_W-1:0]} < LANE_LIM)))
        else $error("symbol outside the table");

endmodule

bind two_level_cdf_symbol_lookup tlcdf_checker #(
    .GROUPS (GROUPS),
    .LANES  (LANES)
) u_tlcdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .symbol    (symbol)
);

### dv/tb.sv
// Testbench for two_level_cdf_symbol_lookup: fills the coarse and fine tables, then mixes
// writes, lookups and ignored requests under random idling on both channels.
// Depends on tlcdf_pkg and the RTL only; the expected symbols are worked out here.
module tb;
    import tlcdf_pkg::*;

    localparam int GROUPS       = 16;
    localparam int LANES        = 16;
    localparam int TABLE_ROWS   = 1 << FIELD_W;
    localparam int RANDOM_ITEMS = 1000;
    localparam int REBUILD_STEP = 500;

    // Operation code the block must ignore
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // Table shapes used when the whole table set is reloaded
    localparam int SHAPE_SPREAD = 0;
    localparam int SHAPE_DENSE  = 1;
    localparam int SHAPE_HIGH   = 2;
    localparam int SHAPE_NOISE  = 3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [OP_W-1:0]     operation = OP_WRITE_COARSE;
    logic [INDEX_W-1:0]  index     = '0;
    logic [VALUE_W-1:0]  value     = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [SYMBOL_W-1:0] symbol;

    bit gapless = 1'b0;

    // Mirror of both tables plus the symbols still owed by the block
    class symbol_scoreboard;
        logic [VALUE_W-1:0]  group_start [TABLE_ROWS];
        logic [VALUE_W-1:0]  lane_offset [TABLE_ROWS*TABLE_ROWS];
        logic [SYMBOL_W-1:0] expected_symbols [$];
        int unsigned         mismatches = 0;

        task report_mismatch(input string what);
            $display("[%0t] symbol mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Apply one accepted request; a lookup yields the symbol it should return
        function void note_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                   input logic [VALUE_W-1:0] val);
            int unsigned        hits;
            logic [FIELD_W-1:0] grp;
            logic [FIELD_W-1:0] lane;
            logic [VALUE_W-1:0] remainder;
            case (op)
                OP_WRITE_COARSE:
                begin
                    if (idx < TABLE_ROWS)
                        group_start[idx[FIELD_W-1:0]] = val;
                end
                OP_WRITE_FINE:
                begin
                    lane_offset[idx] = val;
                end
                OP_LOOKUP:
                begin
                    hits = 0;
                    for (int i = 0; i < GROUPS; i++)
                        if (group_start[i] <= val)
                            hits++;
                    grp = (hits == 0) ? '0 : FIELD_W'(hits - 1);
                    // wraps when the value sits below the group start
                    remainder = val - group_start[grp];
                    hits = 0;
                    for (int i = 0; i < LANES; i++)
                        if (lane_offset[grp * TABLE_ROWS + i] <= remainder)
                            hits++;
                    lane = (hits == 0) ? '0 : FIELD_W'(hits - 1);
                    expected_symbols.push_back({grp, lane});
                end
                default:
                begin
                end
            endcase
        endfunction

        task check_symbol(input logic [SYMBOL_W-1:0] got);
            logic [SYMBOL_W-1:0] want;
            if (expected_symbols.size() == 0)
            begin
                report_mismatch($sformatf("symbol %02h with no lookup pending", got));
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("got %02h, want %02h", got, want));
            end
        endtask
    endclass

    symbol_scoreboard sb;

    two_level_cdf_symbol_lookup #(
        .GROUPS (GROUPS),
        .LANES  (LANES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (operation),
        .index     (index),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .symbol    (symbol)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    // Next table entry for a given shape; carries a spare top bit to saturate
    function automatic logic [VALUE_W:0] ramp_entry(input int unsigned shape, input bit fine_row,
                                                    input int i, input logic [VALUE_W:0] prev);
        int unsigned step_max;
        step_max = fine_row ? (1 << 22) : (1 << 27);
        case (shape)
            SHAPE_SPREAD:
                ramp_entry = (i == 0) ? '0 : prev + $urandom_range(1, step_max);
            SHAPE_DENSE:
                ramp_entry = (i == 0) ? '0 : prev + $urandom_range(0, 3);
            SHAPE_HIGH:
                if (i != 0)
                    ramp_entry = prev + $urandom_range(0, step_max);
                else if (fine_row)
                    ramp_entry = 33'd1 + $urandom_range(0, 999);
                else
                    ramp_entry = 33'h0_8000_0000 + $urandom_range(0, 1 << 30);
            default:
                ramp_entry = {1'b0, $urandom};
        endcase
    endfunction

    // Lookup value aimed at table boundaries or value extremes most of the time
    function automatic logic [VALUE_W-1:0] pick_lookup_value();
        int unsigned        grp;
        int unsigned        lane;
        logic [VALUE_W-1:0] nudge;
        grp   = $urandom_range(0, TABLE_ROWS - 1);
        lane  = $urandom_range(0, TABLE_ROWS - 1);
        nudge = $urandom_range(0, 2) - 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return sb.group_start[grp] + sb.lane_offset[grp * TABLE_ROWS + lane] + nudge;
            2: return sb.group_start[grp] + nudge;
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
        endcase
    endfunction

    // Present one request after an optional gap and hold it until accepted
    task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val);
        int unsigned gap;
        gap = gapless ? 0 : pick_idle();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        operation <= op;
        index     <= idx;
        value     <= val;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(op, idx, val);
    endtask

    // Rewrite every coarse and fine entry with a fresh table of the given shape
    task automatic load_tables(input int unsigned shape);
        logic [VALUE_W:0] acc;
        acc = '0;
        for (int g = 0; g < TABLE_ROWS; g++)
        begin
            acc = ramp_entry(shape, 1'b0, g, acc);
            send_request(OP_WRITE_COARSE, INDEX_W'(g), acc[VALUE_W] ? '1 : acc[VALUE_W-1:0]);
        end
        for (int g = 0; g < TABLE_ROWS; g++)
        begin
            for (int l = 0; l < TABLE_ROWS; l++)
            begin
                acc = ramp_entry(shape, 1'b1, l, acc);
                send_request(OP_WRITE_FINE, INDEX_W'(g * TABLE_ROWS + l),
                             acc[VALUE_W] ? '1 : acc[VALUE_W-1:0]);
            end
        end
    endtask

    // Result side: alternate stalls and runs of ready
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned run;
        @(posedge rst_n);
        forever
        begin
            stall = pick_idle();
            run   = $urandom_range(1, 40);
            repeat (stall)
            begin
                @(negedge clk);
                res_ready <= 1'b0;
            end
            repeat (run)
            begin
                @(negedge clk);
                res_ready <= 1'b1;
            end
        end
    end

    // Check each symbol taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_symbol(symbol);
    end

    initial
    begin : stimulus
        int unsigned        counted;
        int unsigned        next_rebuild;
        int unsigned        kind;
        int unsigned        slot;
        logic [VALUE_W-1:0] v;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill every entry before the first lookup
        load_tables(SHAPE_SPREAD);

        // Extremes, every operation and the corner cases
        send_request(OP_LOOKUP, 8'h00, 32'h0000_0000);
        send_request(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 8'h00, sb.group_start[5]);
        send_request(OP_LOOKUP, 8'h00, sb.group_start[5] - 1);
        send_request(OP_LOOKUP, 8'h00, sb.group_start[15] + sb.lane_offset[255]);
        send_request(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_WRITE_COARSE, 8'd16, 32'hFFFF_FFFF);
        send_request(OP_WRITE_COARSE, 8'hFF, 32'h0000_0000);
        send_request(OP_LOOKUP, 8'h00, sb.group_start[3] + 1);
        send_request(OP_WRITE_FINE, 8'hFF, 32'h0000_0000);
        send_request(OP_LOOKUP, 8'h00, sb.group_start[15] + sb.lane_offset[254]);
        // value below the first group start: empty coarse count and a wrapped remainder
        send_request(OP_WRITE_COARSE, 8'd0, 32'd100);
        send_request(OP_LOOKUP, 8'h00, 32'd50);
        send_request(OP_LOOKUP, 8'h00, 32'd100);
        // remainder below the first lane offset: empty fine count
        send_request(OP_WRITE_FINE, 8'd0, 32'd5);
        send_request(OP_LOOKUP, 8'h00, 32'd102);
        send_request(OP_WRITE_COARSE, 8'd15, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 8'h00, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 8'h00, 32'hFFFF_FFFE);
        send_request(OP_WRITE_COARSE, 8'd0, 32'd0);
        send_request(OP_WRITE_FINE, 8'd0, 32'd0);

        // Random mix, reloading the tables with a new shape every so often
        counted      = 0;
        next_rebuild = REBUILD_STEP;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= next_rebuild)
            begin
                gapless = ($urandom_range(0, 2) == 0);
                load_tables($urandom_range(SHAPE_SPREAD, SHAPE_NOISE));
                next_rebuild += REBUILD_STEP;
                gapless = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 64)
            begin
                send_request(OP_LOOKUP, INDEX_W'($urandom_range(0, 255)), pick_lookup_value());
            end
            else if (kind < 76)
            begin
                // keep most coarse rewrites between their neighbours
                slot = $urandom_range(0, TABLE_ROWS - 1);
                v = $urandom;
                if ($urandom_range(0, 9) < 7 && slot > 0 && slot < TABLE_ROWS - 1 &&
                    sb.group_start[slot + 1] > sb.group_start[slot - 1])
                    v = sb.group_start[slot - 1] +
                        $urandom_range(0, sb.group_start[slot + 1] - sb.group_start[slot - 1]);
                send_request(OP_WRITE_COARSE, INDEX_W'(slot), v);
            end
            else if (kind < 88)
            begin
                v = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 20);
                send_request(OP_WRITE_FINE, INDEX_W'($urandom_range(0, 255)), v);
            end
            else if (kind < 93)
            begin
                send_request(OP_WRITE_COARSE, INDEX_W'($urandom_range(TABLE_ROWS, 255)),
                             $urandom);
            end
            else
            begin
                send_request(OP_RESERVED, INDEX_W'($urandom_range(0, 255)), $urandom);
            end
            counted++;
            if (counted % 100 == 0)
                gapless = ($urandom_range(0, 3) == 0);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Drain, then wait for stray symbols
        while (sb.expected_symbols.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
